>>> src/assert_macros.svh
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Expression never true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

>>> src/hrc_pkg.sv
package hrc_pkg;

	localparam int unsigned THR_W   = 23;
	localparam int unsigned CNT_W   = 16;
	localparam int unsigned POWER_W = 24;
	localparam int unsigned TRUN_W  = 4;
	localparam int unsigned MAXTO_W = 3;
	localparam int unsigned IDX_W   = 3;

	localparam int unsigned IN_TDATA_W  = 32;
	localparam int unsigned OUT_TDATA_W = 8;

	// Register reset values.
	localparam logic [THR_W-1:0]   ON_THRESHOLD_RST  = 23'd750;
	localparam logic [CNT_W-1:0]   ON_COUNT_RST      = 16'd50;
	localparam logic [THR_W-1:0]   OFF_THRESHOLD_RST = 23'd100;
	localparam logic [CNT_W-1:0]   OFF_COUNT_RST     = 16'd20;
	localparam logic [CNT_W-1:0]   TIMEOUT_TICKS_RST = 16'd120;
	localparam logic [MAXTO_W-1:0] MAX_TIMEOUTS_RST  = 3'd3;

	// Register indexes on the configuration port.
	localparam logic [IDX_W-1:0] REG_ON_THRESHOLD  = 3'd0;
	localparam logic [IDX_W-1:0] REG_ON_COUNT      = 3'd1;
	localparam logic [IDX_W-1:0] REG_OFF_THRESHOLD = 3'd2;
	localparam logic [IDX_W-1:0] REG_OFF_COUNT     = 3'd3;
	localparam logic [IDX_W-1:0] REG_TIMEOUT_TICKS = 3'd4;
	localparam logic [IDX_W-1:0] REG_MAX_TIMEOUTS  = 3'd5;

	// Beat kinds carried on tuser.
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_TICK   = 1'b1;

	typedef enum logic [1:0] {
		MODE_FORCE_OFF = 2'd0,
		MODE_FORCE_ON  = 2'd1,
		MODE_AUTO      = 2'd2
	} mode_t;

	function automatic logic [CNT_W-1:0] sat_inc_cnt(input logic [CNT_W-1:0] v);
		return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
	endfunction

	function automatic logic [TRUN_W-1:0] sat_inc_trun(input logic [TRUN_W-1:0] v);
		return (v == {TRUN_W{1'b1}}) ? v : v + 1'b1;
	endfunction

endpackage

>>> src/hysteresis_relay_controller_top.sv
// Channel   Dir  Ports                   Payload
// s_axis    in   tvalid/tready/tdata/    tuser: kind; tdata: power, plug_state, mode
//                tuser
// m_axis    out  tvalid/tready/tdata     tdata: command_on, timed_out, fault
// cfg       in   cfg_we/cfg_index/       register index and write data, no read-back
//                cfg_data
//
// One beat is accepted per cycle while the output is not stalled; a beat is held in the input
// register and its result, if any, is then registered in the output register.
// The rate is set by the single state update per cycle on the run and timeout counters.
// Reset (arst_n low) restores the configuration, state and valid registers and clears the sticky fault.
// An unaccepted output beat stalls the input register, which then stalls s_axis.
// Once the fault is raised, beats are still accepted but are dropped without a result.
`include "assert_macros.svh"

module hysteresis_relay_controller_top
	import hrc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// [23:0] power (signed), [24] plug_state, [26:25] mode, [31:27] zero
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// [0] kind
	input  logic [0:0]             s_axis_tuser,

	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [0] command_on, [1] timed_out, [2] fault, [7:3] zero
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,

	input  logic                   cfg_we,
	input  logic [IDX_W-1:0]       cfg_index,
	input  logic [THR_W-1:0]       cfg_data
);

	// Configuration registers.
	logic [THR_W-1:0]   on_threshold_q;
	logic [CNT_W-1:0]   on_count_q;
	logic [THR_W-1:0]   off_threshold_q;
	logic [CNT_W-1:0]   off_count_q;
	logic [CNT_W-1:0]   timeout_ticks_q;
	logic [MAXTO_W-1:0] max_timeouts_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_threshold_q  <= ON_THRESHOLD_RST;
			on_count_q      <= ON_COUNT_RST;
			off_threshold_q <= OFF_THRESHOLD_RST;
			off_count_q     <= OFF_COUNT_RST;
			timeout_ticks_q <= TIMEOUT_TICKS_RST;
			max_timeouts_q  <= MAX_TIMEOUTS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ON_THRESHOLD:  on_threshold_q  <= cfg_data;
				REG_ON_COUNT:      on_count_q      <= cfg_data[CNT_W-1:0];
				REG_OFF_THRESHOLD: off_threshold_q <= cfg_data;
				REG_OFF_COUNT:     off_count_q     <= cfg_data[CNT_W-1:0];
				REG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data[CNT_W-1:0];
				REG_MAX_TIMEOUTS:  max_timeouts_q  <= cfg_data[MAXTO_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register.
	logic               valid_s1;
	logic               kind_s1;
	logic [POWER_W-1:0] power_s1;
	logic               plug_s1;
	logic [1:0]         mode_s1;

	logic out_valid_q;
	logic advance;
	logic in_accept;

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			kind_s1  <= s_axis_tuser[0];
			power_s1 <= s_axis_tdata[POWER_W-1:0];
			plug_s1  <= s_axis_tdata[POWER_W];
			mode_s1  <= s_axis_tdata[POWER_W+2:POWER_W+1];
		end
	end

	// Controller state.
	logic              relay_q;
	logic [CNT_W-1:0]  high_run_q;
	logic [CNT_W-1:0]  low_run_q;
	logic [CNT_W-1:0]  idle_ticks_q;
	logic [TRUN_W-1:0] timeout_run_q;
	logic              halted_q;

	logic              process;
	logic [CNT_W-1:0]  idle_inc;
	logic [TRUN_W-1:0] trun_inc;
	logic              tick_fire;
	logic              fault_now;
	logic              above;
	logic              below;
	logic [CNT_W-1:0]  high_nx;
	logic [CNT_W-1:0]  low_nx;
	logic              relay_nx;
	logic              emit;
	logic              res_cmd;
	logic              res_to;
	logic              res_fault;

	assign process   = valid_s1 && advance && !halted_q;
	assign idle_inc  = sat_inc_cnt(idle_ticks_q);
	assign trun_inc  = sat_inc_trun(timeout_run_q);
	// A zero timeout setting fires on every tick.
	assign tick_fire = !(idle_inc < timeout_ticks_q);
	assign fault_now = trun_inc > {1'b0, max_timeouts_q};

	// Signed sample against the unsigned thresholds, both seen as 24-bit signed.
	assign above = $signed(power_s1) > $signed({1'b0, on_threshold_q});
	assign below = $signed(power_s1) < $signed({1'b0, off_threshold_q});

	always_comb begin
		high_nx  = above ? sat_inc_cnt(high_run_q) : '0;
		low_nx   = below ? sat_inc_cnt(low_run_q) : '0;
		relay_nx = relay_q;
		case (mode_s1)
			MODE_FORCE_OFF: begin
				relay_nx = 1'b0;
				high_nx  = '0;
				low_nx   = '0;
			end
			MODE_FORCE_ON: begin
				relay_nx = 1'b1;
				high_nx  = '0;
				low_nx   = '0;
			end
			MODE_AUTO: begin
				if (low_nx >= off_count_q) begin
					relay_nx = 1'b0;
					high_nx  = '0;
				end else if (high_nx >= on_count_q) begin
					relay_nx = 1'b1;
					low_nx   = '0;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		if (kind_s1 == KIND_TICK) begin
			emit      = tick_fire;
			res_cmd   = 1'b0;
			res_to    = 1'b1;
			res_fault = fault_now;
		end else begin
			emit      = (relay_nx != relay_q) || (relay_nx != plug_s1);
			res_cmd   = relay_nx;
			res_to    = 1'b0;
			res_fault = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_q       <= 1'b0;
			high_run_q    <= '0;
			low_run_q     <= '0;
			idle_ticks_q  <= '0;
			timeout_run_q <= '0;
			halted_q      <= 1'b0;
		end else if (process) begin
			if (kind_s1 == KIND_TICK) begin
				if (tick_fire) begin
					idle_ticks_q  <= '0;
					timeout_run_q <= trun_inc;
					relay_q       <= 1'b0;
					high_run_q    <= '0;
					low_run_q     <= '0;
					halted_q      <= fault_now;
				end else begin
					idle_ticks_q <= idle_inc;
				end
			end else begin
				idle_ticks_q  <= '0;
				timeout_run_q <= '0;
				high_run_q    <= high_nx;
				low_run_q     <= low_nx;
				relay_q       <= relay_nx;
			end
		end
	end

	// Output register.
	logic cmd_q;
	logic timed_out_q;
	logic fault_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= process && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (process && emit) begin
			cmd_q       <= res_cmd;
			timed_out_q <= res_to;
			fault_q     <= res_fault;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W-3){1'b0}}, fault_q, timed_out_q, cmd_q};

	// The fault is sticky until reset.
	`ASSERT_CLK(a_halt_sticky, clk, arst_n, halted_q |=> halted_q)
	// A faulted result is always an off command caused by a timeout.
	`ASSERT_CLK(a_fault_beat, clk, arst_n,
		(out_valid_q && fault_q) |-> (timed_out_q && !cmd_q))
	// Emitting a fault result halts the controller on the same edge.
	`ASSERT_CLK(a_fault_halts, clk, arst_n,
		(process && emit && res_fault) |=> halted_q)
	// A beat held in the input register is not dropped while the output stalls.
	`ASSERT_CLK(a_s1_kept, clk, arst_n, (valid_s1 && !advance) |=> valid_s1)
	// No state update happens once halted.
	`ASSERT_NEVER(a_no_work_halted, clk, arst_n, process && halted_q)

endmodule

>>> sim/tb.sv
module tb;
	import hrc_pkg::*;

	localparam logic [1:0]       MODE_SPARE   = 2'd3;
	localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int P_MAX       = 8388607;
	localparam int P_MIN       = -8388608;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic               kind;
		logic [POWER_W-1:0] power;
		logic               plug;
		logic [1:0]         mode;
	} relay_beat_t;

	typedef struct packed {
		logic command_on;
		logic timed_out;
		logic fault;
	} relay_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic [0:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [THR_W-1:0] cfg_data = '0;

	hysteresis_relay_controller_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// Settings as the block holds them.
	logic [THR_W-1:0]   on_thr     = ON_THRESHOLD_RST;
	logic [CNT_W-1:0]   on_cnt     = ON_COUNT_RST;
	logic [THR_W-1:0]   off_thr    = OFF_THRESHOLD_RST;
	logic [CNT_W-1:0]   off_cnt    = OFF_COUNT_RST;
	logic [CNT_W-1:0]   tick_limit = TIMEOUT_TICKS_RST;
	logic [MAXTO_W-1:0] to_limit   = MAX_TIMEOUTS_RST;

	// Controller state mirrored beat by beat.
	logic               rly_state = 1'b0;
	logic [CNT_W-1:0]   hi_run    = '0;
	logic [CNT_W-1:0]   lo_run    = '0;
	logic [CNT_W-1:0]   idle_cnt  = '0;
	logic [TRUN_W-1:0]  to_run    = '0;
	logic               halted    = 1'b0;

	relay_beat_t beat_q[$];
	relay_cmd_t  cmd_q[$];
	relay_beat_t cur_beat;
	logic        drain_hold = 1'b0;
	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int beats_in = 0;
	int cmds_seen = 0;
	int reg_writes = 0;
	int err_cnt = 0;
	int cycle_cnt = 0;

	task automatic relay_predict(input relay_beat_t b);
		int p;
		logic nxt;
		relay_cmd_t c;
		if (halted)
			return;
		if (b.kind == KIND_TICK) begin
			if (idle_cnt != '1)
				idle_cnt++;
			// A zero tick limit is met by the very first tick.
			if (idle_cnt < tick_limit)
				return;
			idle_cnt = '0;
			if (to_run != '1)
				to_run++;
			rly_state = 1'b0;
			hi_run = '0;
			lo_run = '0;
			c.command_on = 1'b0;
			c.timed_out = 1'b1;
			c.fault = (to_run > to_limit);
			if (c.fault)
				halted = 1'b1;
			cmd_q.push_back(c);
			return;
		end
		idle_cnt = '0;
		to_run = '0;
		p = $signed(b.power);
		if (p > int'(on_thr)) begin
			if (hi_run != '1)
				hi_run++;
		end else begin
			hi_run = '0;
		end
		if (p < int'(off_thr)) begin
			if (lo_run != '1)
				lo_run++;
		end else begin
			lo_run = '0;
		end
		nxt = rly_state;
		case (b.mode)
			MODE_FORCE_OFF: begin
				nxt = 1'b0;
				hi_run = '0;
				lo_run = '0;
			end
			MODE_FORCE_ON: begin
				nxt = 1'b1;
				hi_run = '0;
				lo_run = '0;
			end
			MODE_AUTO: begin
				if (lo_run >= off_cnt) begin
					nxt = 1'b0;
					hi_run = '0;
				end else if (hi_run >= on_cnt) begin
					nxt = 1'b1;
					lo_run = '0;
				end
			end
			default: ;
		endcase
		if (nxt != rly_state || nxt != b.plug) begin
			rly_state = nxt;
			c.command_on = nxt;
			c.timed_out = 1'b0;
			c.fault = 1'b0;
			cmd_q.push_back(c);
		end
	endtask

	// Sender side: a beat is predicted at the edge where it is accepted.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				relay_predict(cur_beat);
				beats_in++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (drain_hold && cmd_q.size() == 0)
					drain_hold = 1'b0;
				if (beat_q.size() != 0 && !drain_hold &&
						$urandom_range(0, 99) >= send_gap_pct) begin
					cur_beat = beat_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {{(IN_TDATA_W-POWER_W-3){1'b0}},
						cur_beat.mode, cur_beat.plug, cur_beat.power};
					s_axis_tuser <= cur_beat.kind;
					// Now and then hold off until every pending command is out.
					if ($urandom_range(0, 249) == 0)
						drain_hold = 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : result_mon
		relay_cmd_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (cmd_q.size() == 0) begin
					$error("result beat %0h arrived with no command pending", m_axis_tdata);
					err_cnt++;
				end else begin
					want = cmd_q.pop_front();
					cmds_seen++;
					if (m_axis_tdata[0] !== want.command_on) begin
						$error("command_on: expected %0b, got %0b",
							want.command_on, m_axis_tdata[0]);
						err_cnt++;
					end
					if (m_axis_tdata[1] !== want.timed_out) begin
						$error("timed_out: expected %0b, got %0b",
							want.timed_out, m_axis_tdata[1]);
						err_cnt++;
					end
					if (m_axis_tdata[2] !== want.fault) begin
						$error("fault: expected %0b, got %0b", want.fault, m_axis_tdata[2]);
						err_cnt++;
					end
				end
			end
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("** hysteresis_relay_controller_top: FAILED **");
			$finish;
		end
	end

	task automatic write_reg(input logic [IDX_W-1:0] idx, input int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[THR_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_writes++;
		case (idx)
			REG_ON_THRESHOLD:  on_thr = val[THR_W-1:0];
			REG_ON_COUNT:      on_cnt = val[CNT_W-1:0];
			REG_OFF_THRESHOLD: off_thr = val[THR_W-1:0];
			REG_OFF_COUNT:     off_cnt = val[CNT_W-1:0];
			REG_TIMEOUT_TICKS: tick_limit = val[CNT_W-1:0];
			REG_MAX_TIMEOUTS:  to_limit = val[MAXTO_W-1:0];
			default: ;
		endcase
	endtask

	task automatic queue_beat(input logic kind, input int p, input logic plug,
			input logic [1:0] mode);
		relay_beat_t b;
		b.kind = kind;
		b.power = p[POWER_W-1:0];
		b.plug = plug;
		b.mode = mode;
		beat_q.push_back(b);
	endtask

	// Wait until the block has taken every beat and returned every command,
	// then give the pipeline time to retire beats that cause no command.
	task automatic drain_block;
		do
			@(negedge clk);
		while (beat_q.size() != 0 || s_axis_tvalid || cmd_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_pace(input int ph);
		case (ph % 4)
			0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_gap_pct = 59; recv_stall_pct = 0;  end
			2: begin send_gap_pct = 0;  recv_stall_pct = 59; end
			default: begin send_gap_pct = 13; recv_stall_pct = 13; end
		endcase
	endtask

	// Class 0 is above the on threshold, 1 below the off threshold, else in between.
	function automatic int pick_power(input int cls);
		int p;
		int room;
		int lo;
		int hi;
		case (cls)
			0: begin
				room = P_MAX - int'(on_thr);
				if (room <= 0 || $urandom_range(0, 15) == 0)
					p = P_MAX;
				else
					p = int'(on_thr) + 1 +
						int'($urandom_range(0, (room > 1000) ? 999 : room - 1));
			end
			1: begin
				if ($urandom_range(0, 15) == 0)
					p = P_MIN;
				else
					p = int'(off_thr) - 1 - int'($urandom_range(0, 999));
			end
			default: begin
				lo = (on_thr < off_thr) ? int'(on_thr) : int'(off_thr);
				hi = (on_thr < off_thr) ? int'(off_thr) : int'(on_thr);
				case ($urandom_range(0, 2))
					0: p = int'(on_thr);
					1: p = int'(off_thr);
					default: p = lo + int'($urandom_range(0, hi - lo));
				endcase
			end
		endcase
		return p;
	endfunction

	task automatic random_settings;
		int unsigned top;
		top = $urandom_range(50, 3000);
		write_reg(REG_ON_THRESHOLD, top);
		// The off threshold may sit above the on threshold, so both runs can grow.
		write_reg(REG_OFF_THRESHOLD, $urandom_range(0, top + 200));
		write_reg(REG_ON_COUNT, $urandom_range(0, 6));
		write_reg(REG_OFF_COUNT, $urandom_range(0, 6));
		write_reg(REG_TIMEOUT_TICKS, $urandom_range(1, 4));
		write_reg(REG_MAX_TIMEOUTS, $urandom_range(1, 7));
	endtask

	// Mostly runs of samples of one power class; tick bursts stay short enough
	// that the timeout limit is never exceeded, and each ends with a sample.
	task automatic gen_traffic(input int n);
		int made;
		int r;
		int len;
		int cls;
		int k;
		logic plug;
		logic [1:0] md;
		made = 0;
		while (made < n) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				cls = $urandom_range(0, 2);
				len = $urandom_range(1, 10);
				plug = 1'($urandom_range(0, 1));
				if ($urandom_range(0, 9) != 0)
					md = MODE_AUTO;
				else
					md = 2'($urandom_range(0, 3));
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 7) == 0)
						plug = ~plug;
					queue_beat(KIND_SAMPLE, pick_power(cls), plug, md);
				end
				made += len;
			end else if (r < 85) begin
				k = $urandom_range(1, int'(to_limit) * int'(tick_limit));
				for (int i = 0; i < k; i++) begin
					md = 2'($urandom_range(0, 3));
					plug = 1'($urandom_range(0, 1));
					queue_beat(KIND_TICK, int'($urandom), plug, md);
				end
				plug = 1'($urandom_range(0, 1));
				queue_beat(KIND_SAMPLE, pick_power($urandom_range(0, 2)), plug, MODE_AUTO);
				made += k + 1;
			end else begin
				md = 2'($urandom_range(0, 3));
				plug = 1'($urandom_range(0, 1));
				queue_beat($urandom_range(0, 1) == 1 ? KIND_TICK : KIND_SAMPLE,
					int'($urandom), plug, md);
				if (beat_q[$].kind == KIND_TICK) begin
					queue_beat(KIND_SAMPLE, int'($urandom), plug, MODE_AUTO);
					made++;
				end
				made++;
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Settings out of reset: extremes of power, each mode, threshold edges.
		set_pace(0);
		queue_beat(KIND_SAMPLE, P_MAX, 1'b0, MODE_AUTO);
		queue_beat(KIND_SAMPLE, P_MIN, 1'b1, MODE_AUTO);
		queue_beat(KIND_SAMPLE, 0, 1'b0, MODE_FORCE_ON);
		queue_beat(KIND_SAMPLE, 0, 1'b1, MODE_FORCE_ON);
		queue_beat(KIND_SAMPLE, 500, 1'b0, MODE_SPARE);
		queue_beat(KIND_SAMPLE, -1, 1'b1, MODE_FORCE_OFF);
		queue_beat(KIND_SAMPLE, 500, 1'b1, MODE_SPARE);
		queue_beat(KIND_SAMPLE, 500, 1'b0, MODE_SPARE);
		queue_beat(KIND_TICK, -1, 1'b1, MODE_SPARE);
		queue_beat(KIND_SAMPLE, 750, 1'b0, MODE_AUTO);
		queue_beat(KIND_SAMPLE, 100, 1'b0, MODE_AUTO);
		drain_block();

		// Zero off count keeps the relay off in power mode.
		write_reg(REG_ON_THRESHOLD, 0);
		write_reg(REG_ON_COUNT, 0);
		write_reg(REG_OFF_THRESHOLD, P_MAX);
		write_reg(REG_OFF_COUNT, 0);
		queue_beat(KIND_SAMPLE, 5, 1'b1, MODE_AUTO);
		queue_beat(KIND_SAMPLE, P_MAX, 1'b0, MODE_AUTO);
		drain_block();

		// Zero on count switches on at once when the off run cannot complete.
		write_reg(REG_ON_THRESHOLD, P_MAX);
		write_reg(REG_OFF_THRESHOLD, 0);
		write_reg(REG_OFF_COUNT, 65535);
		queue_beat(KIND_SAMPLE, -1, 1'b0, MODE_AUTO);
		queue_beat(KIND_SAMPLE, P_MIN, 1'b1, MODE_AUTO);
		drain_block();

		// A zero tick limit makes every tick a timeout; spare indexes change nothing.
		write_reg(REG_TIMEOUT_TICKS, 0);
		write_reg(REG_MAX_TIMEOUTS, 7);
		write_reg(REG_SPARE_LO, P_MAX);
		write_reg(REG_SPARE_HI, P_MAX);
		queue_beat(KIND_TICK, 0, 1'b0, MODE_AUTO);
		queue_beat(KIND_TICK, 0, 1'b1, MODE_FORCE_ON);
		queue_beat(KIND_TICK, 0, 1'b0, MODE_AUTO);
		queue_beat(KIND_SAMPLE, 0, 1'b0, MODE_FORCE_ON);
		queue_beat(KIND_SAMPLE, 0, 1'b0, MODE_FORCE_OFF);
		drain_block();

		for (int ph = 0; ph < 8; ph++) begin
			set_pace(ph);
			random_settings();
			gen_traffic(150);
			drain_block();
		end

		// Long high run: the relay switches on only once the on count is met.
		set_pace(0);
		write_reg(REG_ON_THRESHOLD, 0);
		write_reg(REG_ON_COUNT, 30);
		write_reg(REG_OFF_THRESHOLD, 0);
		write_reg(REG_OFF_COUNT, 65535);
		write_reg(REG_TIMEOUT_TICKS, 65535);
		queue_beat(KIND_SAMPLE, 0, 1'b0, MODE_FORCE_OFF);
		for (int i = 0; i < 40; i++)
			queue_beat(KIND_SAMPLE, 1 + (i % 7), (i >= 29), MODE_AUTO);
		for (int i = 0; i < 3; i++)
			queue_beat(KIND_TICK, 0, 1'b0, MODE_AUTO);
		queue_beat(KIND_SAMPLE, -5, 1'b0, MODE_AUTO);
		drain_block();

		// No timeout tolerated: the first one raises the fault and the block halts.
		set_pace(3);
		write_reg(REG_MAX_TIMEOUTS, 0);
		write_reg(REG_TIMEOUT_TICKS, 2);
		queue_beat(KIND_SAMPLE, 0, 1'b1, MODE_FORCE_ON);
		queue_beat(KIND_TICK, 0, 1'b1, MODE_AUTO);
		queue_beat(KIND_TICK, 0, 1'b1, MODE_AUTO);
		queue_beat(KIND_SAMPLE, 0, 1'b0, MODE_FORCE_ON);
		queue_beat(KIND_TICK, 0, 1'b0, MODE_AUTO);
		queue_beat(KIND_TICK, 0, 1'b0, MODE_AUTO);
		drain_block();
		write_reg(REG_ON_THRESHOLD, 10);
		queue_beat(KIND_SAMPLE, P_MAX, 1'b1, MODE_FORCE_OFF);
		queue_beat(KIND_SAMPLE, P_MIN, 1'b0, MODE_FORCE_ON);
		drain_block();

		repeat (10) @(negedge clk);
		$display("Run summary: %0d beats accepted, %0d commands checked, %0d register writes.",
			beats_in, cmds_seen, reg_writes);
		$display("Covered forced and power-driven switching, timeouts, a long run %s",
			"and the fault halt.");
		if (err_cnt == 0)
			$display("** hysteresis_relay_controller_top: PASSED **");
		else
			$display("** hysteresis_relay_controller_top: FAILED **");
		$finish;
	end

endmodule
